FILE: sv/tpcs_pkg.sv
// Shared types and constants for the timer prescaler and compare select unit.
package tpcs_pkg;

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMP_W  = 8;
  localparam int unsigned SEL_W  = 3;

  // Counter range of the timer (count must lie in 1..COUNTER_STEPS)
  localparam int unsigned COUNTER_STEPS = 256;

  // Clock register reset value
  localparam logic [DATA_W-1:0] CPU_CLOCK_RESET = DATA_W'(16000000);

  // Divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = DATA_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Prescalers are all powers of two: 1, 8, 32, 64, 128, 256, 1024
  localparam int unsigned NUM_PRESC = 7;
  localparam int unsigned PRESC_SHIFT [NUM_PRESC] = '{0, 3, 5, 6, 7, 8, 10};

  // Clock-select code for "no prescaler fits"; code i+1 selects entry i
  localparam logic [SEL_W-1:0] CS_NONE = SEL_W'(0);

  // Divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // One result
  typedef struct packed {
    logic             found;
    logic [CMP_W-1:0] compare_value;
    logic [SEL_W-1:0] clock_select;
  } res_t;

endpackage

FILE: sv/tpcs_if.sv
// Request and result channel interfaces.
interface tpcs_req_if;
  logic                         valid;
  logic                         ready;
  logic [tpcs_pkg::DATA_W-1:0]  target_hz;

  modport source (output valid, output target_hz, input ready);
  modport sink   (input valid, input target_hz, output ready);
endinterface

interface tpcs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [tpcs_pkg::CMP_W-1:0]   compare_value;
  logic [tpcs_pkg::SEL_W-1:0]   clock_select;

  modport source (output valid, output found, output compare_value, output clock_select,
                  input ready);
  modport sink   (input valid, input found, input compare_value, input clock_select,
                  output ready);
endinterface

FILE: sv/tpcs_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module tpcs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tpcs_pkg::DATA_W-1:0]  dividend,
  input  logic [tpcs_pkg::DATA_W-1:0]  divisor,
  output tpcs_pkg::div_status_t        status,
  output logic [tpcs_pkg::DATA_W-1:0]  quotient
);

  logic [tpcs_pkg::DATA_W-1:0] rem;
  logic [tpcs_pkg::DATA_W-1:0] quo;
  logic [tpcs_pkg::DATA_W-1:0] dvs;
  logic [tpcs_pkg::CNT_W-1:0]  cnt;
  logic                        busy;
  logic                        done;

  logic [tpcs_pkg::DATA_W:0]   trial;
  logic [tpcs_pkg::DATA_W:0]   diff;
  logic                        fits;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem, quo[tpcs_pkg::DATA_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Dividend shifts out of quo while quotient bits shift in
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= tpcs_pkg::CNT_W'(tpcs_pkg::DIV_STEPS - 1);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? diff[tpcs_pkg::DATA_W-1:0] : trial[tpcs_pkg::DATA_W-1:0];
        quo <= {quo[tpcs_pkg::DATA_W-2:0], fits};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

FILE: sv/tpcs_sel.sv
// Prescaler pick: first power-of-two shift of the quotient that lands in range.
module tpcs_sel (
  input  logic [tpcs_pkg::DATA_W-1:0] quotient,
  input  logic                        zero_target,
  output tpcs_pkg::res_t              res
);

  logic [tpcs_pkg::DATA_W-1:0] count [tpcs_pkg::NUM_PRESC];
  logic [tpcs_pkg::NUM_PRESC-1:0] hit;

  // clk / (p * f) == (clk / f) >> log2(p) for power-of-two p
  always_comb begin
    for (int i = 0; i < tpcs_pkg::NUM_PRESC; i++) begin
      count[i] = quotient >> tpcs_pkg::PRESC_SHIFT[i];
      hit[i]   = (count[i] != '0) &&
                 ({1'b0, count[i]} <= (tpcs_pkg::DATA_W+1)'(tpcs_pkg::COUNTER_STEPS));
    end
  end

  // Lowest prescaler wins: scan from the top so earlier entries override
  always_comb begin
    res.found         = 1'b0;
    res.compare_value = '0;
    res.clock_select  = tpcs_pkg::CS_NONE;
    if (!zero_target) begin
      for (int i = tpcs_pkg::NUM_PRESC - 1; i >= 0; i--) begin
        if (hit[i]) begin
          res.found         = 1'b1;
          res.compare_value = tpcs_pkg::CMP_W'(count[i] - tpcs_pkg::DATA_W'(1));
          res.clock_select  = tpcs_pkg::SEL_W'(i + 1);
        end
      end
    end
  end

endmodule

FILE: sv/timer_prescaler_compare_select_unit.sv
// Top level: CTC prescaler and compare value selection from a requested tick rate.
//
// Usage:
//   cfg_wr_en / cfg_wr_data write the CPU clock in hertz (reset 16000000).
//   Write it only while no request is in flight.
//   req carries target_hz; rsp returns found, compare_value and clock_select.
//   A zero target, or no prescaler giving a count of 1..256, returns all zeros.
// Timing:
//   One request at a time. After acceptance the bit-serial divider forms
//   cpu_clock_hz / target_hz, one quotient bit per cycle; the prescaler pick
//   then works on that quotient by fixed shifts. The result passes through
//   the hold state into the output register, and req.ready returns in the
//   same cycle as the result is loaded.
// Reset:
//   rst (synchronous, active high) empties the output register, stops the
//   divider and restores the clock register.
// Stall:
//   A result waits in the output register until rsp.ready; a finished
//   quotient is held until the register frees, and no new request is taken.
module timer_prescaler_compare_select_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [tpcs_pkg::DATA_W-1:0] cfg_wr_data,
  tpcs_req_if.sink                    req,
  tpcs_rsp_if.source                  rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t                      state;
  logic [tpcs_pkg::DATA_W-1:0] cpu_clock_hz;
  logic                        zero_target;
  logic                        rsp_valid;
  tpcs_pkg::res_t              res;

  logic                        accept;
  logic                        load_res;
  tpcs_pkg::div_status_t       div_stat;
  logic [tpcs_pkg::DATA_W-1:0] quotient;
  tpcs_pkg::res_t              sel_res;

  // Clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_clock_hz <= tpcs_pkg::CPU_CLOCK_RESET;
    end else if (cfg_wr_en) begin
      cpu_clock_hz <= cfg_wr_data;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // Finished result moves into the output register once it is free
  assign load_res  = (state == S_HOLD) && (!rsp_valid || rsp.ready);

  tpcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (cpu_clock_hz),
    .divisor  (req.target_hz),
    .status   (div_stat),
    .quotient (quotient)
  );

  tpcs_sel u_sel (
    .quotient    (quotient),
    .zero_target (zero_target),
    .res         (sel_res)
  );

  // Request sequencing and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (load_res) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            zero_target <= (req.target_hz == '0);
            state       <= S_RUN;
          end
        end
        S_RUN: begin
          if (div_stat.done) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_res) begin
            res   <= sel_res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.found         = res.found;
  assign rsp.compare_value = res.compare_value;
  assign rsp.clock_select  = res.clock_select;

  // Checks
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> div_stat.busy)
    else $error("divider not running after request accepted");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_RUN))
    else $error("divider finished outside run state");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !req.ready)
    else $error("request ready while divider busy");

  a_found_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.found == (rsp.clock_select != tpcs_pkg::CS_NONE)))
    else $error("found flag disagrees with clock select");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.compare_value == '0))
    else $error("nonzero compare value without a fit");

endmodule

FILE: dv/tb_top.sv
// Testbench for the timer prescaler and compare select unit: self-checking, random and directed.
`timescale 1ns / 100ps

module tb_top;

  // Prescaler shifts of the timer, in the order they are tried
  localparam int unsigned RATE_SHIFT [7] = '{0, 3, 5, 6, 7, 8, 10};
  localparam int unsigned TIMER_STEPS = 256;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned PHASE_REQUESTS = 300;
  localparam int unsigned CLOCK_HOLD = 75;
  localparam logic [31:0] RESET_CLOCK = 32'd16000000;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [tpcs_pkg::DATA_W-1:0] cfg_wr_data;

  tpcs_req_if rate_req ();
  tpcs_rsp_if setting_rsp ();

  timer_prescaler_compare_select_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (rate_req),
    .rsp         (setting_rsp)
  );

  // Predictor state and checker bookkeeping
  logic [31:0] model_cpu_clock;
  tpcs_pkg::res_t timer_settings_q [$];
  int unsigned fail_count = 0;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected timer setting for one requested rate at a given CPU clock
  function automatic tpcs_pkg::res_t predict_setting(input logic [31:0] rate_hz,
                                                     input logic [31:0] cpu_hz);
    tpcs_pkg::res_t pick;
    longint unsigned ticks;
    pick = '0;
    if (rate_hz != 0) begin
      for (int i = 0; i < 7; i++) begin
        ticks = longint'(cpu_hz) / (longint'(rate_hz) << RATE_SHIFT[i]);
        if (!pick.found && ticks >= 1 && ticks <= TIMER_STEPS) begin
          pick.found = 1'b1;
          pick.compare_value = tpcs_pkg::CMP_W'(ticks - 1);
          pick.clock_select = tpcs_pkg::SEL_W'(i + 1);
        end
      end
    end
    return pick;
  endfunction

  // Random rate, mostly aimed at a random count in or just past some prescaler's window
  function automatic logic [31:0] pick_rate();
    int unsigned kind;
    longint unsigned ticks;
    longint unsigned base;
    kind = $urandom_range(9);
    if (kind < 7) begin
      ticks = $urandom_range(258, 1);
      base = longint'(model_cpu_clock) / (ticks << RATE_SHIFT[kind]);
      return 32'(base + $urandom_range(2) - 1);
    end else if (kind == 7) begin
      return $urandom;
    end else if (kind == 8) begin
      return $urandom_range(4096);
    end
    return 32'd1 << $urandom_range(31);
  endfunction

  // Send one request and record its expected setting once accepted
  task automatic send_rate(input logic [31:0] rate_hz);
    while ($urandom_range(99) < send_idle_pct) begin
      rate_req.valid <= 1'b0;
      @(posedge clk);
    end
    rate_req.valid <= 1'b1;
    rate_req.target_hz <= rate_hz;
    @(posedge clk);
    while (!rate_req.ready) @(posedge clk);
    timer_settings_q.push_back(predict_setting(rate_hz, model_cpu_clock));
  endtask

  // Hold off the sender until every request has been answered
  task automatic wait_settled();
    rate_req.valid <= 1'b0;
    while (timer_settings_q.size() != 0) @(posedge clk);
  endtask

  // Write the CPU clock register; only called while the unit is idle
  task automatic load_cpu_clock(input logic [31:0] cpu_hz);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cpu_hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_cpu_clock = cpu_hz;
    @(posedge clk);
  endtask

  // Result checker and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      setting_rsp.ready <= 1'b0;
    end else begin
      if (setting_rsp.valid && setting_rsp.ready) begin
        if (timer_settings_q.size() == 0) begin
          $error("unexpected result: found=%0d compare_value=%0d clock_select=%0d",
                 setting_rsp.found, setting_rsp.compare_value, setting_rsp.clock_select);
          fail_count++;
        end else begin
          tpcs_pkg::res_t want;
          want = timer_settings_q.pop_front();
          if (setting_rsp.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, setting_rsp.found);
            fail_count++;
          end
          if (setting_rsp.compare_value !== want.compare_value) begin
            $error("compare_value: expected %0d, got %0d",
                   want.compare_value, setting_rsp.compare_value);
            fail_count++;
          end
          if (setting_rsp.clock_select !== want.clock_select) begin
            $error("clock_select: expected %0d, got %0d",
                   want.clock_select, setting_rsp.clock_select);
            fail_count++;
          end
        end
      end
      setting_rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if (rst || (rate_req.valid && rate_req.ready) ||
        (setting_rsp.valid && setting_rsp.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Rates around each prescaler window at the reset clock of 16 MHz
  task automatic test_reset_clock();
    logic [31:0] rates [$];
    rates = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd62500, 32'd62501, 32'd7812, 32'd2000,
              32'd1000, 32'd500, 32'd250, 32'd61, 32'd60, 32'd16000000, 32'd16000001};
    foreach (rates[i]) send_rate(rates[i]);
    wait_settled();
  endtask

  // Extreme clock settings, zero clock included
  task automatic test_clock_extremes();
    load_cpu_clock(32'hFFFF_FFFF);
    send_rate(32'd1);
    send_rate(32'd16777215);
    send_rate(32'hFFFF_FFFF);
    wait_settled();
    load_cpu_clock(32'd1);
    send_rate(32'd1);
    send_rate(32'd2);
    wait_settled();
    load_cpu_clock(32'd0);
    send_rate(32'd1);
    send_rate(32'd0);
    wait_settled();
  endtask

  // Random rates under one idling setting, with clock changes between bursts
  task automatic test_random_phase(input int unsigned sender_idle,
                                   input int unsigned receiver_stall);
    int unsigned pick;
    send_idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int n = 0; n < PHASE_REQUESTS; n++) begin
      if (n % CLOCK_HOLD == 0) begin
        wait_settled();
        pick = $urandom_range(5);
        unique case (pick)
          0: load_cpu_clock(RESET_CLOCK);
          1: load_cpu_clock(32'hFFFF_FFFF);
          2: load_cpu_clock($urandom_range(1000, 1));
          3: load_cpu_clock($urandom_range(32'h1000_0000, 32'h0010_0000));
          default: load_cpu_clock($urandom);
        endcase
      end
      send_rate(pick_rate());
    end
    wait_settled();
  endtask

  // Stimulus sequence
  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    rate_req.valid = 1'b0;
    rate_req.target_hz = '0;
    model_cpu_clock = RESET_CLOCK;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_clock();
    test_clock_extremes();
    test_random_phase(0, 0);
    test_random_phase(76, 0);
    test_random_phase(0, 76);
    test_random_phase(29, 29);

    // Let any stray result show up before the verdict
    stall_pct = 0;
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: timer_prescaler_compare_select_unit.f
sv/tpcs_pkg.sv
sv/tpcs_if.sv
sv/tpcs_div.sv
sv/tpcs_sel.sv
sv/timer_prescaler_compare_select_unit.sv
dv/tb_top.sv
